// File: hw/rtl/i2crx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2crx_pkg
// Shared constants and types for the I2C slave receiver with FIFO flow control.
// ----------------------------------------------------------------------------
package i2crx_pkg;

    localparam int FIFO_DEPTH_DEF = 64;

    // item kinds
    localparam logic [1:0] KIND_BUS    = 2'd0;
    localparam logic [1:0] KIND_TICK   = 2'd1;
    localparam logic [1:0] KIND_POP    = 2'd2;
    localparam logic [1:0] KIND_RESUME = 2'd3;

    // bus status codes, prescaler bits masked off
    localparam logic [7:0] ST_OWN_SLA_W = 8'h60;
    localparam logic [7:0] ST_DATA_ACK  = 8'h80;
    localparam logic [7:0] ST_DATA_NACK = 8'h88;
    localparam logic [7:0] ST_STOP      = 8'hA0;
    localparam logic [7:0] ST_PRESCALE  = 8'h03;

    localparam logic [15:0] TICKS_MAX = 16'hFFFF;

    // register indexes
    localparam logic [1:0] REG_HIGH_WATER    = 2'd0;
    localparam logic [1:0] REG_LOW_WATER     = 2'd1;
    localparam logic [1:0] REG_TIMEOUT_LIMIT = 2'd2;

    localparam logic [6:0]  HIGH_WATER_RST    = 7'd48;
    localparam logic [6:0]  LOW_WATER_RST     = 7'd16;
    localparam logic [15:0] TIMEOUT_LIMIT_RST = 16'd2000;

    // flags of one result, pop byte comes from the FIFO RAM
    typedef struct packed {
        logic       ack_enable;
        logic       notify_read;
        logic       notify_timeout;
        logic       byte_lost;
        logic       pop_valid;
        logic [6:0] fill_level;
    } t_result;

endpackage

// File: hw/rtl/i2c_slave_rx_flow_control.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_slave_rx_flow_control
// I2C slave receiver flow control with a receive FIFO and water marks.
// ----------------------------------------------------------------------------
// One item per clock: an input transfer is taken whenever the output register
// is empty or is being drained in the same cycle, and its result is held in
// the output register until taken. Control state (pointers, fill count, ACK
// flag, timeout count) is registered when an item is taken; received bytes
// live in a synchronous FIFO RAM whose registered read data lines up with the
// output register, so a pop returns its byte along with its result. The
// FIFO RAM needs no clearing after reset: only written entries are ever read.
// Registers: 0x0 high water (7 bit), 0x4 low water (7 bit), 0x8 timeout
// limit (16 bit).
module i2c_slave_rx_flow_control #(
    parameter int FIFO_DEPTH = i2crx_pkg::FIFO_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // status_code[7:0], rx_byte[15:8]
    input  logic [1:0]  s_axis_tuser,   // kind[1:0]
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // ack_enable[0], notify_read[1], notify_timeout[2], byte_lost[3],
    // pop_data[11:4], pop_valid[12], fill_level[19:13], zero[23:20]
    output logic [23:0] m_axis_tdata,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

    logic [6:0]  r_high_water;
    logic [6:0]  r_low_water;
    logic [15:0] r_timeout_limit;

    logic                r_out_valid;
    i2crx_pkg::t_result  r_result;
    i2crx_pkg::t_result  result;

    logic          in_accept;
    logic          mem_we;
    logic          mem_re;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    logic [7:0]    mem_wdata;
    logic [7:0]    mem_rdata;
    logic [7:0]    pop_data;
    logic          cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_water    <= i2crx_pkg::HIGH_WATER_RST;
            r_low_water     <= i2crx_pkg::LOW_WATER_RST;
            r_timeout_limit <= i2crx_pkg::TIMEOUT_LIMIT_RST;
        end else if (cfg_write) begin
            case (paddr[3:2])
                i2crx_pkg::REG_HIGH_WATER:    r_high_water    <= pwdata[6:0];
                i2crx_pkg::REG_LOW_WATER:     r_low_water     <= pwdata[6:0];
                i2crx_pkg::REG_TIMEOUT_LIMIT: r_timeout_limit <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            i2crx_pkg::REG_HIGH_WATER:    prdata = 32'(r_high_water);
            i2crx_pkg::REG_LOW_WATER:     prdata = 32'(r_low_water);
            i2crx_pkg::REG_TIMEOUT_LIMIT: prdata = 32'(r_timeout_limit);
            default:                      prdata = '0;
        endcase
    end

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    i2crx_ctrl #(
        .FIFO_DEPTH (FIFO_DEPTH),
        .AW         (AW)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (in_accept),
        .i_kind          (s_axis_tuser),
        .i_status_code   (s_axis_tdata[7:0]),
        .i_rx_byte       (s_axis_tdata[15:8]),
        .i_high_water    (r_high_water),
        .i_low_water     (r_low_water),
        .i_timeout_limit (r_timeout_limit),
        .o_mem_we        (mem_we),
        .o_mem_waddr     (mem_waddr),
        .o_mem_wdata     (mem_wdata),
        .o_mem_re        (mem_re),
        .o_mem_raddr     (mem_raddr),
        .o_result        (result)
    );

    i2crx_ram #(
        .DEPTH (FIFO_DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_out_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_result <= result;
        end
    end

    // RAM read data is held until the next valid pop is taken
    assign pop_data = r_result.pop_valid ? mem_rdata : 8'h00;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000,
                            r_result.fill_level,
                            r_result.pop_valid,
                            pop_data,
                            r_result.byte_lost,
                            r_result.notify_timeout,
                            r_result.notify_read,
                            r_result.ack_enable};

endmodule

// File: hw/rtl/i2crx_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2crx_ram
// Receive FIFO storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module i2crx_ram #(
    parameter int DEPTH = i2crx_pkg::FIFO_DEPTH_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/i2crx_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2crx_ctrl
// FIFO pointers, fill count, ACK and timeout state; decides each item's result
// and issues the FIFO RAM write or read.
// ----------------------------------------------------------------------------
module i2crx_ctrl #(
    parameter int FIFO_DEPTH = i2crx_pkg::FIFO_DEPTH_DEF,
    parameter int AW         = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [1:0]          i_kind,
    input  logic [7:0]          i_status_code,
    input  logic [7:0]          i_rx_byte,
    input  logic [6:0]          i_high_water,
    input  logic [6:0]          i_low_water,
    input  logic [15:0]         i_timeout_limit,
    output logic                o_mem_we,
    output logic [AW-1:0]       o_mem_waddr,
    output logic [7:0]          o_mem_wdata,
    output logic                o_mem_re,
    output logic [AW-1:0]       o_mem_raddr,
    output i2crx_pkg::t_result  o_result
);

    localparam int CW   = $clog2(FIFO_DEPTH + 1);
    localparam int CMPW = (CW > 7) ? CW : 7;
    localparam logic [CW-1:0] FULL_COUNT = CW'(FIFO_DEPTH);
    localparam logic [AW-1:0] LAST_INDEX = AW'(FIFO_DEPTH - 1);

    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          r_ack, n_ack;
    logic          r_receiving, n_receiving;
    logic [15:0]   r_ticks, n_ticks;

    logic            full;
    logic [7:0]      status;
    logic [CMPW-1:0] cur_count_ext;
    logic [CMPW-1:0] high_ext;
    logic [CMPW-1:0] low_ext;

    assign status        = i_status_code & ~i2crx_pkg::ST_PRESCALE;
    assign full          = (r_count == FULL_COUNT);
    assign cur_count_ext = CMPW'(r_count);
    assign high_ext      = CMPW'(i_high_water);
    assign low_ext       = CMPW'(i_low_water);

    always_comb begin
        n_wr_ptr    = r_wr_ptr;
        n_rd_ptr    = r_rd_ptr;
        n_count     = r_count;
        n_ack       = r_ack;
        n_receiving = r_receiving;
        n_ticks     = r_ticks;
        o_mem_we    = 1'b0;
        o_mem_re    = 1'b0;
        o_mem_waddr = r_wr_ptr;
        o_mem_wdata = i_rx_byte;
        o_mem_raddr = r_rd_ptr;
        o_result    = '0;

        case (i_kind)
            i2crx_pkg::KIND_BUS: begin
                case (status)
                    i2crx_pkg::ST_OWN_SLA_W: begin
                        n_ticks = 16'd1;
                        if (!full) begin
                            n_ack       = 1'b1;
                            n_receiving = 1'b1;
                        end else begin
                            n_ack                = 1'b0;
                            n_receiving          = 1'b0;
                            o_result.notify_read = 1'b1;
                        end
                    end
                    i2crx_pkg::ST_DATA_ACK: begin
                        n_ticks = 16'd1;
                        if (!full) begin
                            o_mem_we = i_accept;
                            n_wr_ptr = (r_wr_ptr == LAST_INDEX) ? '0 : r_wr_ptr + AW'(1);
                            n_count  = r_count + CW'(1);
                            if (CMPW'(n_count) > high_ext) begin
                                n_ack                = 1'b0;
                                n_receiving          = 1'b0;
                                o_result.notify_read = 1'b1;
                            end else begin
                                n_ack       = 1'b1;
                                n_receiving = 1'b1;
                            end
                        end else begin
                            n_ack                = 1'b0;
                            n_receiving          = 1'b0;
                            o_result.notify_read = 1'b1;
                            o_result.byte_lost   = 1'b1;
                        end
                    end
                    i2crx_pkg::ST_DATA_NACK: begin
                        if (cur_count_ext < low_ext) begin
                            n_ack       = 1'b1;
                            n_receiving = 1'b1;
                        end else begin
                            n_ack                = 1'b0;
                            n_receiving          = 1'b0;
                            o_result.notify_read = 1'b1;
                        end
                    end
                    i2crx_pkg::ST_STOP: begin
                        n_ticks              = '0;
                        o_result.notify_read = 1'b1;
                        n_ack                = 1'b1;
                        n_receiving          = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            i2crx_pkg::KIND_TICK: begin
                if (r_ticks != '0) begin
                    if (r_ticks != i2crx_pkg::TICKS_MAX) begin
                        n_ticks = r_ticks + 16'd1;
                    end
                    o_result.notify_timeout = (n_ticks > i_timeout_limit);
                end
            end
            i2crx_pkg::KIND_POP: begin
                if (r_count != '0) begin
                    o_mem_re           = i_accept;
                    o_result.pop_valid = 1'b1;
                    n_rd_ptr = (r_rd_ptr == LAST_INDEX) ? '0 : r_rd_ptr + AW'(1);
                    n_count  = r_count - CW'(1);
                end
            end
            default: begin
                n_ack = 1'b1;
            end
        endcase

        o_result.ack_enable = n_ack;
        o_result.fill_level = 7'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_count     <= '0;
            r_ack       <= 1'b1;
            r_receiving <= 1'b0;
            r_ticks     <= '0;
        end else if (i_accept) begin
            r_wr_ptr    <= n_wr_ptr;
            r_rd_ptr    <= n_rd_ptr;
            r_count     <= n_count;
            r_ack       <= n_ack;
            r_receiving <= n_receiving;
            r_ticks     <= n_ticks;
        end
    end

endmodule

// File: test/rx_flow_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rx_flow_checker
// Watches the item, result and register ports of the I2C slave receiver and
// predicts every result from its own copy of the FIFO, flags and registers.
// Each result transfer is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module rx_flow_checker #(
    parameter int DEPTH = i2crx_pkg::FIFO_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [15:0] i_s_tdata,   // status_code[7:0], rx_byte[15:8]
    input  logic [1:0]  i_s_tuser,   // kind[1:0]
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [23:0] i_m_tdata,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [3:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_pready,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked,
    output int          o_lost,
    output int          o_expired
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef struct packed {
        logic       ack_enable;
        logic       notify_read;
        logic       notify_timeout;
        logic       byte_lost;
        logic [7:0] pop_data;
        logic       pop_valid;
        logic [6:0] fill_level;
    } t_rx_result;

    t_rx_result  result_q[$];

    logic [7:0]    store [DEPTH];
    logic [PW-1:0] wr_ptr;
    logic [PW-1:0] rd_ptr;
    int            fill_cnt;
    logic          ack_flag;
    logic [15:0]   tick_cnt;

    logic [6:0]  cfg_high;
    logic [6:0]  cfg_low;
    logic [15:0] cfg_timeout;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
        o_lost       = 0;
        o_expired    = 0;
    end

    function automatic t_rx_result apply_item(input logic [1:0] kind,
                                              input logic [7:0] raw_status,
                                              input logic [7:0] data);
        t_rx_result r;
        logic [7:0] status;
        logic       full;
        r      = '0;
        status = raw_status & ~i2crx_pkg::ST_PRESCALE;
        full   = (fill_cnt >= DEPTH);
        case (kind)
            i2crx_pkg::KIND_BUS: begin
                if (status == i2crx_pkg::ST_OWN_SLA_W) begin
                    tick_cnt = 16'd1;
                    if (!full) begin
                        ack_flag = 1'b1;
                    end else begin
                        ack_flag      = 1'b0;
                        r.notify_read = 1'b1;
                    end
                end else if (status == i2crx_pkg::ST_DATA_ACK) begin
                    tick_cnt = 16'd1;
                    if (!full) begin
                        store[wr_ptr] = data;
                        wr_ptr        = (int'(wr_ptr) == DEPTH - 1) ? '0 : wr_ptr + PW'(1);
                        fill_cnt++;
                        if (fill_cnt > cfg_high) begin
                            ack_flag      = 1'b0;
                            r.notify_read = 1'b1;
                        end else begin
                            ack_flag = 1'b1;
                        end
                    end else begin
                        // byte arrives on a full FIFO and is dropped
                        ack_flag      = 1'b0;
                        r.notify_read = 1'b1;
                        r.byte_lost   = 1'b1;
                    end
                end else if (status == i2crx_pkg::ST_DATA_NACK) begin
                    if (fill_cnt < cfg_low) begin
                        ack_flag = 1'b1;
                    end else begin
                        ack_flag      = 1'b0;
                        r.notify_read = 1'b1;
                    end
                end else if (status == i2crx_pkg::ST_STOP) begin
                    tick_cnt      = 16'd0;
                    ack_flag      = 1'b1;
                    r.notify_read = 1'b1;
                end
            end
            i2crx_pkg::KIND_TICK: begin
                if (tick_cnt != 16'd0) begin
                    if (tick_cnt != i2crx_pkg::TICKS_MAX)
                        tick_cnt = tick_cnt + 16'd1;
                    if (tick_cnt > cfg_timeout)
                        r.notify_timeout = 1'b1;
                end
            end
            i2crx_pkg::KIND_POP: begin
                if (fill_cnt > 0) begin
                    r.pop_data  = store[rd_ptr];
                    r.pop_valid = 1'b1;
                    rd_ptr      = (int'(rd_ptr) == DEPTH - 1) ? '0 : rd_ptr + PW'(1);
                    fill_cnt--;
                end
            end
            default: begin
                ack_flag = 1'b1;
            end
        endcase
        r.ack_enable = ack_flag;
        r.fill_level = 7'(fill_cnt);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_rx_result want;
        t_rx_result got;
        if (!i_rst_n) begin
            result_q.delete();
            foreach (store[k])
                store[k] = 8'h00;
            wr_ptr      = '0;
            rd_ptr      = '0;
            fill_cnt    = 0;
            ack_flag    = 1'b1;
            tick_cnt    = 16'd0;
            cfg_high    = i2crx_pkg::HIGH_WATER_RST;
            cfg_low     = i2crx_pkg::LOW_WATER_RST;
            cfg_timeout = i2crx_pkg::TIMEOUT_LIMIT_RST;
        end else begin
            // result first: it always belongs to an earlier item
            if (i_m_tvalid && i_m_tready) begin
                if (result_q.size() == 0) begin
                    $error("result transfer 0x%06h with no item outstanding", i_m_tdata);
                    o_fail_count++;
                end else begin
                    want = result_q.pop_front();
                    check_field("ack_enable", 32'(want.ack_enable), 32'(i_m_tdata[0]));
                    check_field("notify_read", 32'(want.notify_read), 32'(i_m_tdata[1]));
                    check_field("notify_timeout", 32'(want.notify_timeout),
                                32'(i_m_tdata[2]));
                    check_field("byte_lost", 32'(want.byte_lost), 32'(i_m_tdata[3]));
                    check_field("pop_data", 32'(want.pop_data), 32'(i_m_tdata[11:4]));
                    check_field("pop_valid", 32'(want.pop_valid), 32'(i_m_tdata[12]));
                    check_field("fill_level", 32'(want.fill_level),
                                32'(i_m_tdata[19:13]));
                    check_field("pad", 32'd0, 32'(i_m_tdata[23:20]));
                    o_checked++;
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                got = apply_item(i_s_tuser, i_s_tdata[7:0], i_s_tdata[15:8]);
                if (got.byte_lost)
                    o_lost++;
                if (got.notify_timeout)
                    o_expired++;
                result_q.push_back(got);
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[3:2])
                    i2crx_pkg::REG_HIGH_WATER:    cfg_high    = i_pwdata[6:0];
                    i2crx_pkg::REG_LOW_WATER:     cfg_low     = i_pwdata[6:0];
                    i2crx_pkg::REG_TIMEOUT_LIMIT: cfg_timeout = i_pwdata[15:0];
                    default: ;
                endcase
            end
        end
        o_pending = result_q.size();
    end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the I2C slave receiver flow control block.
// Runs a short directed sequence, then randomized bus frames (own address,
// data bytes, NACKs, STOPs, ticks, pops) under several water mark and timeout
// settings with random gaps and stalls, and finally runs an armed counter
// well past a short limit. Checking is done by rx_flow_checker.
// ----------------------------------------------------------------------------
module tb_top;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;   // status_code[7:0], rx_byte[15:8]
    logic [1:0]  s_axis_tuser = '0;   // kind[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b1;
    // ack_enable[0], notify_read[1], notify_timeout[2], byte_lost[3],
    // pop_data[11:4], pop_valid[12], fill_level[19:13], zero[23:20]
    logic [23:0] m_axis_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int pending;
    int checked;
    int lost_seen;
    int expired_seen;

    int n_sent = 0;
    int n_settings = 1;
    bit gaps_on = 1'b1;
    bit stalls_on = 1'b1;
    int stall_left = 0;

    i2c_slave_rx_flow_control i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    rx_flow_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_lost       (lost_seen),
        .o_expired    (expired_seen)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // mostly short idle stretches, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            m_axis_tready = 1'b0;
            stall_left--;
        end else begin
            m_axis_tready = 1'b1;
            if (stalls_on)
                stall_left = pick_gap();
        end
    end

    // returns right after the rising edge that took the transfer
    task automatic send_item(input logic [1:0] kind, input logic [7:0] status,
                             input logic [7:0] data);
        int gap;
        gap = gaps_on ? pick_gap() : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = kind;
        s_axis_tdata  = {data, status};
        do @(posedge i_clk); while (!s_axis_tready);
        n_sent++;
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_regs(input logic [6:0] high, input logic [6:0] low,
                            input logic [15:0] limit);
        reg_write(i2crx_pkg::REG_HIGH_WATER, {25'd0, high});
        reg_write(i2crx_pkg::REG_LOW_WATER, {25'd0, low});
        reg_write(i2crx_pkg::REG_TIMEOUT_LIMIT, {16'd0, limit});
        n_settings++;
    endtask

    function automatic logic [7:0] code(input logic [7:0] base);
        return base | 8'($urandom_range(0, 3));
    endfunction

    // one bus frame: own address, a run of bytes mixed with other items,
    // mostly closed by a STOP
    task automatic run_frame();
        int bias;
        int len;
        int r;
        bias = $urandom_range(30, 80);
        len  = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 90) : $urandom_range(0, 20);
        send_item(i2crx_pkg::KIND_BUS, code(i2crx_pkg::ST_OWN_SLA_W), 8'($urandom));
        for (int j = 0; j < len; j++) begin
            r = $urandom_range(0, 99);
            if (r < bias)
                send_item(i2crx_pkg::KIND_BUS, code(i2crx_pkg::ST_DATA_ACK), 8'($urandom));
            else if (r < bias + 8)
                send_item(i2crx_pkg::KIND_TICK, 8'($urandom), 8'($urandom));
            else if (r < bias + 11)
                send_item(i2crx_pkg::KIND_BUS, code(i2crx_pkg::ST_DATA_NACK), 8'($urandom));
            else if (r < bias + 13)
                send_item(i2crx_pkg::KIND_RESUME, 8'($urandom), 8'($urandom));
            else
                send_item(i2crx_pkg::KIND_POP, 8'($urandom), 8'($urandom));
        end
        if ($urandom_range(0, 5) != 0)
            send_item(i2crx_pkg::KIND_BUS, code(i2crx_pkg::ST_STOP), 8'($urandom));
        repeat ($urandom_range(0, len))
            send_item(i2crx_pkg::KIND_POP, 8'($urandom), 8'($urandom));
    endtask

    task automatic run_random(input int count);
        int stop_at;
        stop_at = n_sent + count;
        while (n_sent < stop_at) begin
            gaps_on   = ($urandom_range(0, 3) != 0);
            stalls_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) < 8) begin
                run_frame();
            end else begin
                repeat ($urandom_range(1, 6))
                    send_item(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom));
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty pop, idle tick, unknown codes, a short frame
        send_item(i2crx_pkg::KIND_POP, 8'h00, 8'h00);
        send_item(i2crx_pkg::KIND_TICK, 8'hFF, 8'hFF);
        send_item(i2crx_pkg::KIND_BUS, 8'h00, 8'h00);
        send_item(i2crx_pkg::KIND_BUS, 8'hFF, 8'hFF);
        send_item(i2crx_pkg::KIND_RESUME, 8'h55, 8'hAA);
        send_item(i2crx_pkg::KIND_BUS, 8'h63, 8'h5A);
        send_item(i2crx_pkg::KIND_BUS, 8'h81, 8'h00);
        send_item(i2crx_pkg::KIND_BUS, 8'h82, 8'hFF);
        send_item(i2crx_pkg::KIND_BUS, 8'h8B, 8'h12);
        send_item(i2crx_pkg::KIND_TICK, 8'h00, 8'h00);
        send_item(i2crx_pkg::KIND_POP, 8'h00, 8'h00);
        send_item(i2crx_pkg::KIND_POP, 8'h00, 8'h00);
        send_item(i2crx_pkg::KIND_POP, 8'h00, 8'h00);
        send_item(i2crx_pkg::KIND_BUS, 8'hA2, 8'h00);
        send_item(i2crx_pkg::KIND_TICK, 8'h00, 8'h00);
        run_random(180);
        wait_idle();

        set_regs(7'd127, 7'd0, 16'd0);
        run_random(180);
        wait_idle();

        set_regs(7'd0, 7'd64, 16'hFFFF);
        run_random(180);
        wait_idle();

        set_regs(7'd64, 7'd127, 16'd1);
        run_random(180);
        wait_idle();

        repeat (3) begin
            set_regs(7'($urandom_range(0, 64)), 7'($urandom_range(0, 64)),
                     16'($urandom_range(1, 40)));
            run_random(180);
            wait_idle();
        end

        // armed counter passes a short limit and keeps reporting expiry
        set_regs(i2crx_pkg::HIGH_WATER_RST, i2crx_pkg::LOW_WATER_RST, 16'd3);
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        send_item(i2crx_pkg::KIND_BUS, code(i2crx_pkg::ST_OWN_SLA_W), 8'h00);
        repeat (8) send_item(i2crx_pkg::KIND_TICK, 8'($urandom), 8'($urandom));
        send_item(i2crx_pkg::KIND_BUS, code(i2crx_pkg::ST_STOP), 8'h00);
        send_item(i2crx_pkg::KIND_TICK, 8'h00, 8'h00);
        wait_idle();

        $display("Run covered %0d input transfers over %0d register settings, %0d checked",
                 n_sent, n_settings, checked);
        $display("Dropped bytes seen: %0d, timeout expiries seen: %0d",
                 lost_seen, expired_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
